// ===== design/pair_sum_counter_macros.svh =====
// ============================================================================
// pair_sum_counter_macros.svh
// Assertion macros shared by the pair sum counter RTL; empty in synthesis.
// ============================================================================
`ifndef PAIR_SUM_COUNTER_MACROS_SVH
`define PAIR_SUM_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define PSC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSC_ASSERT(label, prop, msg)
`define PSC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== design/psc_pkg.sv =====
// ============================================================================
// psc_pkg
// Shared widths, limits and the token type passed along the cell row.
// ============================================================================
package psc_pkg;

	localparam int DATA_W        = 32;
	localparam int COUNT_W       = 19;
	localparam int SUM_W         = COUNT_W + 1;
	localparam int OUT_TDATA_W   = 24;
	localparam int DEF_MAX_ITEMS = 1024;
	localparam int DEF_MATCH_W   = $clog2(DEF_MAX_ITEMS + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// One query/insert token moving down the row
	typedef struct packed {
		logic              valid;   // slot carries an item
		logic              key_ok;  // key lies in the 32-bit range
		logic              last;    // item closes the set
		logic              store;   // item gets a cell (store not full)
		logic              placed;  // item already took its cell
		logic [DATA_W-1:0] key;     // value a partner must hold
		logic [DATA_W-1:0] value;   // the item's own value
	} tok_t;

endpackage

// ===== design/pair_sum_counter.sv =====
// ============================================================================
// pair_sum_counter
// Counts pairs within a set of values whose sum equals a target value.
// ============================================================================
//
//  channel  | direction | beat contents
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | tdata = item_value, tlast = last_in_set
//  m_*      | out       | tdata = pair_count, tuser = store_overflow,
//           |           | tlast = set_done
//  cfg_*    | in        | data = target_sum, always ready
//
//  One beat per cycle unless the result stream stalls; each input beat passes
//  one entry stage, then one stage per cell of the row, then the result stage.
//  Reset clears every cell at once; no clearing pass is needed.
//  A stalled result (m_tready low) freezes the whole row and drops s_tready.
//  Each set starts fresh after its last beat; the closing beat empties each
//  cell as it passes, so the next set may follow directly behind it.
//
// The values of a set live in a row of MAX_ITEMS cells, filled from the front.
// Each beat becomes a token that walks the row one cell per unstalled cycle,
// counting cells holding target_sum - item_value and claiming the first free
// cell. Tokens never overtake, so every token sees exactly the earlier values.

`include "pair_sum_counter_macros.svh"

module pair_sum_counter
	import psc_pkg::*;
#(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,   // [31:0] item_value
	input  logic                   s_tlast,   // last_in_set
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [18:0] pair_count, [23:19] zero
	output logic                   m_tuser,   // [0] store_overflow
	output logic                   m_tlast,   // set_done
	// configuration
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [DATA_W-1:0]      cfg_data   // target_sum
);

	localparam int MATCH_W = $clog2(MAX_ITEMS + 1);
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1);

	logic [DATA_W-1:0]  target_q;
	logic [CNT_W-1:0]   cnt_q;
	tok_t               tok_s1;
	logic               adv;
	logic               accept;
	logic signed [DATA_W:0] want;
	tok_t               tok_chain [MAX_ITEMS+1];
	logic [MATCH_W-1:0] mat_chain [MAX_ITEMS+1];

	logic               m_valid_q;
	logic [COUNT_W-1:0] m_count_q;
	logic               m_ovf_q;
	logic               m_last_q;
	logic [COUNT_W-1:0] run_q;
	logic [SUM_W-1:0]   sum;
	logic [COUNT_W-1:0] sat;
	tok_t               tok_end;

	// The whole row moves whenever the result register can take a beat.
	assign adv      = !m_valid_q || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// Target register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_valid) begin
			target_q <= cfg_data;
		end
	end

	// ------------------------------------------------------------------
	// Entry stage: form the partner key at full width, track fill level
	// ------------------------------------------------------------------
	assign want = $signed({target_q[DATA_W-1], target_q}) - $signed({s_tdata[DATA_W-1], s_tdata});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			tok_s1 <= '0;
		end else if (adv) begin
			tok_s1.valid  <= s_tvalid;
			tok_s1.key_ok <= (want[DATA_W] == want[DATA_W-1]);
			tok_s1.last   <= s_tlast;
			tok_s1.store  <= (cnt_q < CNT_W'(MAX_ITEMS));
			tok_s1.placed <= 1'b0;
			tok_s1.key    <= want[DATA_W-1:0];
			tok_s1.value  <= s_tdata;
			if (accept) begin
				// restart the fill level after the closing beat
				if (s_tlast) begin
					cnt_q <= '0;
				end else if (cnt_q < CNT_W'(MAX_ITEMS)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Cell row
	// ------------------------------------------------------------------
	assign tok_chain[0] = tok_s1;
	assign mat_chain[0] = '0;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_row
		psc_cell #(
			.MATCH_W (MATCH_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tok_chain[i]),
			.mat_in  (mat_chain[i]),
			.tok_out (tok_chain[i+1]),
			.mat_out (mat_chain[i+1])
		);
	end

	assign tok_end = tok_chain[MAX_ITEMS];

	// ------------------------------------------------------------------
	// Result stage: add this beat's matches to the running count, saturate
	// ------------------------------------------------------------------
	assign sum = SUM_W'(run_q) + SUM_W'(mat_chain[MAX_ITEMS]);
	assign sat = sum[SUM_W-1] ? COUNT_MAX : sum[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			run_q     <= '0;
		end else if (adv) begin
			m_valid_q <= tok_end.valid;
			if (tok_end.valid) begin
				// drop the count once the set is closed
				run_q <= tok_end.last ? '0 : sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok_end.valid) begin
			m_count_q <= sat;
			m_ovf_q   <= !tok_end.store;
			m_last_q  <= tok_end.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TDATA_W'(m_count_q);
	assign m_tuser  = m_ovf_q;
	assign m_tlast  = m_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`PSC_ASSERT_ALWAYS(a_reset_clears, (!arst_n |=> (!m_tvalid && cnt_q == '0)), "reset left state")
	`PSC_ASSERT(a_fill_bound, (cnt_q <= CNT_W'(MAX_ITEMS)), "fill level past store size")
	`PSC_ASSERT(a_close_restarts, ((s_tvalid && s_tready && s_tlast) |=> (cnt_q == '0)), "set did not restart fill")
	`PSC_ASSERT(a_done_clears, ((m_tvalid && m_tready && m_tlast) |=> (run_q == '0)), "count not cleared after set")
	`PSC_ASSERT(a_count_grows, ((m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid || (m_tdata[COUNT_W-1:0] >= $past(m_tdata[COUNT_W-1:0])))), "count fell inside a set")

endmodule

// ===== design/psc_cell.sv =====
// ============================================================================
// psc_cell
// One storage cell: compares the passing token, takes its value, hands it on.
// ============================================================================
module psc_cell
	import psc_pkg::*;
#(
	parameter int MATCH_W = DEF_MATCH_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  tok_t               tok_in,
	input  logic [MATCH_W-1:0] mat_in,
	output tok_t               tok_out,
	output logic [MATCH_W-1:0] mat_out
);

	logic              valid_q;
	logic [DATA_W-1:0] value_q;
	tok_t              tok_q;
	tok_t              tok_nxt;
	logic [MATCH_W-1:0] mat_q;
	logic              hit;
	logic              take;

	assign hit  = tok_in.valid && tok_in.key_ok && valid_q && (value_q == tok_in.key);
	// the first free cell on the way belongs to the token
	assign take = tok_in.valid && tok_in.store && !tok_in.placed && !valid_q;

	// mark the token as placed once it has claimed this cell
	always_comb begin
		tok_nxt        = tok_in;
		tok_nxt.placed = tok_in.placed | take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
			mat_q   <= '0;
		end else if (adv) begin
			tok_q        <= tok_nxt;
			mat_q        <= hit ? mat_in + MATCH_W'(1) : mat_in;
			// the closing item empties every cell it passes
			if (tok_in.valid && tok_in.last) begin
				valid_q <= 1'b0;
			end else if (take) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			value_q <= tok_in.value;
		end
	end

	assign tok_out = tok_q;
	assign mat_out = mat_q;

endmodule
